// ----- rtl/fvn_pkg.sv -----
// Shared constants, register codes and the per-slot sideband type for the
// fractal value noise block. No dependencies.
package fvn_pkg;

  localparam int DEF_MAX_OCTAVES = 8;

  localparam int COORD_W    = 32;
  localparam int HEIGHT_W   = 28;
  localparam int PERS_W     = 17;
  localparam int FREQ_W     = 24;
  localparam int AMP_W      = 24;
  localparam int OCT_CNT_W  = 4;
  localparam int SEED_W     = 12;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int WEIGHT_W   = 32;
  localparam int CONTRIB_W  = 64;

  // Result queue depth; also bounds transactions in flight.
  localparam int FIFO_DEPTH = 32;

  localparam logic [CFG_IDX_W-1:0] REG_PERSISTENCE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_FREQUENCY = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_AMPLITUDE      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OCTAVE_COUNT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SEED           = 3'd4;

  localparam logic [WEIGHT_W-1:0] ONE_Q16 = 32'd65536;

  localparam logic signed [HEIGHT_W-1:0] HEIGHT_MAX = 28'sh7ffffff;
  localparam logic signed [HEIGHT_W-1:0] HEIGHT_MIN = 28'sh8000000;

  // Sideband that travels with one octave slot.
  typedef struct packed {
    logic                first;
    logic                last;
    logic                zero;
    logic [WEIGHT_W-1:0] weight;
  } fvn_tag_t;

endpackage

// ----- rtl/fvn_octave.sv -----
// Twelve-stage octave pipeline: coordinate scaling, 16 lattice hashes,
// corner smoothing, smoothstep blends and octave weighting. Uses fvn_pkg.
module fvn_octave #(
  parameter int MAX_OCTAVES = fvn_pkg::DEF_MAX_OCTAVES,
  parameter int KW = (MAX_OCTAVES > 1) ? $clog2(MAX_OCTAVES) : 1
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 slot_valid,
  input  fvn_pkg::fvn_tag_t                    slot_tag,
  input  logic [fvn_pkg::COORD_W-1:0]          slot_cx,
  input  logic [fvn_pkg::COORD_W-1:0]          slot_cy,
  input  logic [KW-1:0]                        slot_k,
  input  logic [fvn_pkg::FREQ_W-1:0]           base_frequency,
  input  logic [fvn_pkg::SEED_W-1:0]           seed,
  output logic                                 res_valid,
  output fvn_pkg::fvn_tag_t                    res_tag,
  output logic signed [fvn_pkg::CONTRIB_W-1:0] res_contrib
);

  localparam int NST = 12;
  localparam logic [31:0] HASH_MUL   = 32'd15731;
  localparam logic [31:0] HASH_ADD   = 32'd789221;
  localparam logic [31:0] HASH_FINAL = 32'd1376312589;

  typedef struct packed {
    logic [31:0]        lat;
    logic signed [17:0] frac;
  } fvn_axis_t;

  typedef logic signed [31:0] fvn_grid_t [16];

  // Cell index and signed Q16 fraction of one scaled axis.
  function automatic fvn_axis_t split_axis(input logic [55:0] p, input logic neg,
                                           input logic [KW-1:0] k,
                                           input logic [24:0] off);
    logic [71:0] ps;
    logic [39:0] ip;
    logic [31:0] fp;
    logic [31:0] off32;
    logic [32:0] inv;
    fvn_axis_t   r;
    ps    = {16'b0, p} << k;
    ip    = ps[71:32];
    fp    = ps[31:0];
    off32 = {7'b0, off};
    inv   = 33'h1_0000_0000 - {1'b0, fp};
    if (!neg) begin
      r.lat  = off32 + ip[31:0];
      r.frac = {2'b0, fp[31:16]};
    end else if (fp == 32'd0) begin
      r.lat  = off32 - ip[31:0];
      r.frac = '0;
    end else if (ip < {15'b0, off}) begin
      r.lat  = off32 - ip[31:0] - 32'd1;
      r.frac = {1'b0, inv[32:16]};
    end else begin
      r.lat  = off32 - ip[31:0];
      r.frac = -$signed({2'b0, fp[31:16]});
    end
    return r;
  endfunction

  // 3x3 smoothing around grid point (cx, cy): diagonals 1, edges 2, center 4.
  function automatic logic signed [36:0] smooth(input fvn_grid_t g, input int cx,
                                                input int cy);
    logic signed [36:0] diag;
    logic signed [36:0] edg;
    diag = 37'(g[(cy-1)*4 + cx-1]) + 37'(g[(cy-1)*4 + cx+1])
         + 37'(g[(cy+1)*4 + cx-1]) + 37'(g[(cy+1)*4 + cx+1]);
    edg  = 37'(g[cy*4 + cx-1]) + 37'(g[cy*4 + cx+1])
         + 37'(g[(cy-1)*4 + cx]) + 37'(g[(cy+1)*4 + cx]);
    return diag + (edg <<< 1) + (37'(g[cy*4 + cx]) <<< 2);
  endfunction

  logic              vld [1:NST];
  fvn_pkg::fvn_tag_t tg  [1:NST];

  // stage 1
  logic [55:0] s1_px, s1_py;
  logic        s1_negx, s1_negy;
  logic [KW-1:0] s1_k;
  // stage 2
  logic [31:0]        s2_xc, s2_yc;
  logic signed [17:0] s2_ax, s2_ay;
  // stage 3..6 hash lanes
  logic [31:0] s3_n2 [16];
  logic [31:0] s4_n2 [16];
  logic [31:0] s4_sq [16];
  logic [31:0] s5_n2 [16];
  logic [31:0] s5_u  [16];
  fvn_grid_t   s6_g;
  // fade weights: 0 = w0x, 1 = w1x, 2 = w0y, 3 = w1y
  logic signed [17:0] s3_q  [4];
  logic signed [35:0] s3_sq [4];
  logic signed [21:0] s4_w  [4];
  logic signed [21:0] s5_w  [4];
  logic signed [21:0] s6_w  [4];
  logic signed [21:0] s7_w  [4];
  logic signed [21:0] s8_wy [2];
  logic signed [21:0] s9_wy [2];
  // stage 7..12
  logic signed [36:0] s7_c  [4];
  logic signed [58:0] s8_p  [4];
  logic signed [43:0] s9_r0, s9_r1;
  logic signed [65:0] s10_q0, s10_q1;
  logic signed [32:0] s11_oct;
  logic signed [fvn_pkg::CONTRIB_W-1:0] s12_contrib;

  logic [31:0] mag_x, mag_y;
  logic [24:0] off;
  fvn_axis_t   ax_x, ax_y;
  logic [31:0] n2_c [16];
  logic [31:0] hx, hy, hn;
  logic signed [55:0] cube [4];
  logic signed [55:0] fv   [4];
  logic [31:0] t_c [16];
  logic signed [59:0] sum_r0, sum_r1;
  logic signed [66:0] sum_oct;
  logic signed [65:0] prod_w;

  // Lattice X comes from coord_y, lattice Y from coord_x.
  assign mag_x = slot_cy[31] ? (32'd0 - slot_cy) : slot_cy;
  assign mag_y = slot_cx[31] ? (32'd0 - slot_cx) : slot_cx;
  assign off   = 25'd2 + ({13'b0, seed} * {13'b0, seed});
  assign ax_x  = split_axis(s1_px, s1_negx, s1_k, off);
  assign ax_y  = split_axis(s1_py, s1_negy, s1_k, off);

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      hx      = s2_xc + 32'(i & 3) - 32'd1;
      hy      = s2_yc + 32'(i >> 2) - 32'd1;
      hn      = hx + hy * 32'd57;
      n2_c[i] = (hn << 13) ^ hn;
      t_c[i]  = s5_n2[i] * s5_u[i] + HASH_FINAL;
    end
    for (int j = 0; j < 4; j++) begin
      cube[j] = 56'(s3_sq[j]) * 56'(s3_q[j]);
      fv[j]   = 56'(s3_sq[j]) * 56'sd196608 - 56'sd2 * cube[j];
    end
    sum_r0  = 60'(s8_p[0]) + 60'(s8_p[1]);
    sum_r1  = 60'(s8_p[2]) + 60'(s8_p[3]);
    sum_oct = 67'(s10_q0) + 67'(s10_q1);
    prod_w  = 66'(s11_oct) * 66'($signed({1'b0, tg[11].weight}));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 1; i <= NST; i++) vld[i] <= 1'b0;
    end else begin
      vld[1] <= slot_valid;
      for (int i = 2; i <= NST; i++) vld[i] <= vld[i-1];
    end
  end

  always_ff @(posedge clk) begin
    tg[1] <= slot_tag;
    for (int i = 2; i <= NST; i++) tg[i] <= tg[i-1];

    s1_px   <= {24'b0, mag_x} * {32'b0, base_frequency};
    s1_py   <= {24'b0, mag_y} * {32'b0, base_frequency};
    s1_negx <= slot_cy[31];
    s1_negy <= slot_cx[31];
    s1_k    <= slot_k;

    s2_xc <= ax_x.lat;
    s2_ax <= ax_x.frac;
    s2_yc <= ax_y.lat;
    s2_ay <= ax_y.frac;

    s3_q[0] <= 18'sd65536 - s2_ax;
    s3_q[1] <= s2_ax;
    s3_q[2] <= 18'sd65536 - s2_ay;
    s3_q[3] <= s2_ay;
    s3_sq[0] <= 36'(18'sd65536 - s2_ax) * 36'(18'sd65536 - s2_ax);
    s3_sq[1] <= 36'(s2_ax) * 36'(s2_ax);
    s3_sq[2] <= 36'(18'sd65536 - s2_ay) * 36'(18'sd65536 - s2_ay);
    s3_sq[3] <= 36'(s2_ay) * 36'(s2_ay);

    for (int i = 0; i < 16; i++) begin
      s3_n2[i] <= n2_c[i];
      s4_n2[i] <= s3_n2[i];
      s4_sq[i] <= s3_n2[i] * s3_n2[i];
      s5_n2[i] <= s4_n2[i];
      s5_u[i]  <= s4_sq[i] * HASH_MUL + HASH_ADD;
      s6_g[i]  <= 32'sd1073741824 - $signed({1'b0, t_c[i][30:0]});
    end

    for (int j = 0; j < 4; j++) begin
      s4_w[j] <= fv[j][53:32];
      s5_w[j] <= s4_w[j];
      s6_w[j] <= s5_w[j];
      s7_w[j] <= s6_w[j];
    end

    s7_c[0] <= smooth(s6_g, 1, 1);
    s7_c[1] <= smooth(s6_g, 2, 1);
    s7_c[2] <= smooth(s6_g, 1, 2);
    s7_c[3] <= smooth(s6_g, 2, 2);

    s8_p[0]  <= 59'(s7_c[0]) * 59'(s7_w[0]);
    s8_p[1]  <= 59'(s7_c[1]) * 59'(s7_w[1]);
    s8_p[2]  <= 59'(s7_c[2]) * 59'(s7_w[0]);
    s8_p[3]  <= 59'(s7_c[3]) * 59'(s7_w[1]);
    s8_wy[0] <= s7_w[2];
    s8_wy[1] <= s7_w[3];

    s9_r0    <= sum_r0[59:16];
    s9_r1    <= sum_r1[59:16];
    s9_wy[0] <= s8_wy[0];
    s9_wy[1] <= s8_wy[1];

    s10_q0 <= 66'(s9_r0) * 66'(s9_wy[0]);
    s10_q1 <= 66'(s9_r1) * 66'(s9_wy[1]);

    s11_oct <= sum_oct[66:34];

    s12_contrib <= tg[11].zero ? '0 : prod_w[fvn_pkg::CONTRIB_W-1:0];
  end

  assign res_valid   = vld[NST];
  assign res_tag     = tg[NST];
  assign res_contrib = s12_contrib;

endmodule

// ----- rtl/fractal_value_noise_2d.sv -----
// Fractal 2-D value noise: one Q16.16 point in, one saturated Q12.16 height out
// per transaction. Each point takes max(1, min(octave_count, MAX_OCTAVES))
// octave issue slots, one octave per cycle into a fully pipelined octave unit
// (16 lattice hashes per octave), so with one octave a new point is taken
// every cycle while fewer than 32 transactions are in flight. Up to 32
// transactions may be in flight; results queue in a 32-entry buffer, and a
// stalled output side stops acceptance only once 32 transactions are in flight.
// Configuration must be kept fixed by the user while transactions are in
// flight; the block itself does not enforce this. Depends on fvn_pkg
// and fvn_octave.
module fractal_value_noise_2d #(
  parameter int MAX_OCTAVES = fvn_pkg::DEF_MAX_OCTAVES
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_wr_en,
  input  logic [fvn_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [fvn_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [fvn_pkg::COORD_W-1:0]   coord_x,
  input  logic signed [fvn_pkg::COORD_W-1:0]   coord_y,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [fvn_pkg::HEIGHT_W-1:0]  height
);

  localparam int KW   = (MAX_OCTAVES > 1) ? $clog2(MAX_OCTAVES) : 1;
  localparam int CNTW = fvn_pkg::OCT_CNT_W + 1;
  localparam logic [CNTW-1:0] MAX_CNT = CNTW'(MAX_OCTAVES);
  localparam int AW   = $clog2(fvn_pkg::FIFO_DEPTH);
  localparam int OW   = $clog2(fvn_pkg::FIFO_DEPTH + 1);
  localparam logic [OW-1:0] DEPTH_O = OW'(fvn_pkg::FIFO_DEPTH);

  logic [fvn_pkg::PERS_W-1:0]    persistence;
  logic [fvn_pkg::FREQ_W-1:0]    base_frequency;
  logic [fvn_pkg::AMP_W-1:0]     amplitude;
  logic [fvn_pkg::OCT_CNT_W-1:0] octave_count;
  logic [fvn_pkg::SEED_W-1:0]    seed;

  always_ff @(posedge clk) begin
    if (rst) begin
      persistence    <= '0;
      base_frequency <= '0;
      amplitude      <= '0;
      octave_count   <= '0;
      seed           <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        fvn_pkg::REG_PERSISTENCE:    persistence    <= cfg_data[fvn_pkg::PERS_W-1:0];
        fvn_pkg::REG_BASE_FREQUENCY: base_frequency <= cfg_data[fvn_pkg::FREQ_W-1:0];
        fvn_pkg::REG_AMPLITUDE:      amplitude      <= cfg_data[fvn_pkg::AMP_W-1:0];
        fvn_pkg::REG_OCTAVE_COUNT:   octave_count   <= cfg_data[fvn_pkg::OCT_CNT_W-1:0];
        fvn_pkg::REG_SEED:           seed           <= cfg_data[fvn_pkg::SEED_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- octave issue ----------------
  logic          active;
  logic [KW-1:0] k, last_k;
  logic          zero_item;
  logic [fvn_pkg::COORD_W-1:0]  cx_q, cy_q;
  logic [fvn_pkg::WEIGHT_W-1:0] weight;
  logic [48:0]   weight_prod;
  logic [CNTW-1:0] cnt_clamp, cnt_last;
  logic          issue_last;
  logic          in_fire, out_fire;
  logic [OW-1:0] outstanding;

  assign cnt_clamp   = ({1'b0, octave_count} < MAX_CNT) ? {1'b0, octave_count} : MAX_CNT;
  assign cnt_last    = (cnt_clamp == '0) ? '0 : cnt_clamp - CNTW'(1);
  assign weight_prod = {17'b0, weight} * {32'b0, persistence};
  assign issue_last  = active && (k == last_k);
  assign in_ready    = (!active || issue_last) && (outstanding < DEPTH_O);
  assign in_fire     = in_valid && in_ready;
  assign out_fire    = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      k      <= '0;
    end else if (in_fire) begin
      active <= 1'b1;
      k      <= '0;
    end else if (issue_last) begin
      active <= 1'b0;
    end else if (active) begin
      k <= k + KW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      cx_q      <= coord_x;
      cy_q      <= coord_y;
      last_k    <= cnt_last[KW-1:0];
      zero_item <= (cnt_clamp == '0);
      weight    <= fvn_pkg::ONE_Q16;
    end else if (active) begin
      weight <= weight_prod[47:16];
    end
  end

  fvn_pkg::fvn_tag_t slot_tag;
  fvn_pkg::fvn_tag_t res_tag;
  logic              res_valid;
  logic signed [fvn_pkg::CONTRIB_W-1:0] res_contrib;

  assign slot_tag.first  = (k == '0);
  assign slot_tag.last   = issue_last;
  assign slot_tag.zero   = zero_item;
  assign slot_tag.weight = weight;

  fvn_octave #(
    .MAX_OCTAVES(MAX_OCTAVES),
    .KW(KW)
  ) u_octave (
    .clk(clk),
    .rst(rst),
    .slot_valid(active),
    .slot_tag(slot_tag),
    .slot_cx(cx_q),
    .slot_cy(cy_q),
    .slot_k(k),
    .base_frequency(base_frequency),
    .seed(seed),
    .res_valid(res_valid),
    .res_tag(res_tag),
    .res_contrib(res_contrib)
  );

  // ---------------- octave sum and output gain ----------------
  logic signed [63:0] acc, acc_next;
  logic               fin_valid;
  logic signed [63:0] fin_sum;
  logic               z1_valid, z1_neg;
  logic [63:0]        z1_mag;
  logic               z2_valid, z2_neg;
  logic [55:0]        z2_lo, z2_hi;
  logic [87:0]        prod;
  logic [56:0]        r_up;
  logic signed [fvn_pkg::HEIGHT_W-1:0] h_val;

  assign acc_next = (res_tag.first ? 64'sd0 : acc) + res_contrib;

  always_comb begin
    prod = ({32'b0, z2_hi} << 32) + {32'b0, z2_lo};
    r_up = {1'b0, prod[87:32]} + {56'b0, (prod[31:0] != 32'd0)};
    if (!z2_neg) begin
      h_val = (prod[87:32] > 56'(fvn_pkg::HEIGHT_MAX)) ? fvn_pkg::HEIGHT_MAX
                                                        : $signed(prod[59:32]);
    end else begin
      h_val = (r_up > 57'h8000000) ? fvn_pkg::HEIGHT_MIN : -$signed(r_up[27:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fin_valid <= 1'b0;
      z1_valid  <= 1'b0;
      z2_valid  <= 1'b0;
    end else begin
      fin_valid <= res_valid && res_tag.last;
      z1_valid  <= fin_valid;
      z2_valid  <= z1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) acc <= acc_next;
    fin_sum <= acc_next;
    z1_neg  <= fin_sum[63];
    z1_mag  <= fin_sum[63] ? (64'd0 - fin_sum) : fin_sum;
    z2_neg  <= z1_neg;
    z2_lo   <= {24'b0, z1_mag[31:0]} * {32'b0, amplitude};
    z2_hi   <= {24'b0, z1_mag[63:32]} * {32'b0, amplitude};
  end

  // ---------------- result queue ----------------
  logic [fvn_pkg::HEIGHT_W-1:0] mem [fvn_pkg::FIFO_DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [OW-1:0] fifo_cnt;
  logic          push, pop;

  assign push = z2_valid;
  assign pop  = (fifo_cnt != '0) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= h_val;
    if (pop) height <= $signed(mem[rd_ptr]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr      <= '0;
      rd_ptr      <= '0;
      fifo_cnt    <= '0;
      out_valid   <= 1'b0;
      outstanding <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + AW'(1);
      if (pop) rd_ptr <= rd_ptr + AW'(1);
      fifo_cnt    <= fifo_cnt + OW'(push) - OW'(pop);
      outstanding <= outstanding + OW'(in_fire) - OW'(out_fire);
      if (pop) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTH
  a_outstanding_bound: assert property (@(posedge clk) disable iff (rst)
    outstanding <= DEPTH_O)
    else $error("transactions in flight exceed queue depth");

  a_queue_covered: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, fifo_cnt} + {{OW{1'b0}}, out_valid}) <= {1'b0, outstanding})
    else $error("queued results exceed transactions in flight");

  a_issue_starts: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> active && (k == '0))
    else $error("accepted transaction did not start octave issue");

  a_done_has_credit: assert property (@(posedge clk) disable iff (rst)
    push |-> (fifo_cnt < DEPTH_O))
    else $error("result written into a full queue");
`endif

endmodule
